// ===== rtl/i8dq_pkg.sv =====
// Package for the int8 block dequantizer: defaults, the work item type and a helper function.
// Used by all files of the block but the checker; depends on nothing.
`timescale 1ns / 1ps
package i8dq_pkg;
  localparam int unsigned BlockElemDefault = 32;
  localparam logic [30:0] ScaleLimitReset = 31'h461C4000;
  localparam int unsigned QueueDepth = 2;

  // Item handed from the front (classification) to the back (multiply).
  typedef struct packed {
    logic [7:0]  quant;
    logic [31:0] scale;
    logic [4:0]  index;
    logic        last;
  } work_t;

  // Widen a half-precision pattern to single precision bits.
  function automatic logic [31:0] half_to_single(input logic [15:0] h);
    logic        s;
    logic [4:0]  ex;
    logic [9:0]  man;
    logic [3:0]  lz;
    logic [9:0]  nm;
    logic [31:0] r;
    s   = h[15];
    ex  = h[14:10];
    man = h[9:0];
    lz  = 4'd0;
    nm  = '0;
    r   = '0;
    if (ex == 5'd0) begin
      if (man == 10'd0) begin
        r = {s, 31'd0};
      end else begin
        // Find the leading one of the subnormal mantissa
        for (int i = 0; i < 10; i++) begin
          if (man[i]) lz = 4'(9 - i);
        end
        nm = man << (lz + 4'd1);
        // value = man * 2^-24, leading bit at 9-lz -> exponent -15-lz
        r = {s, 8'(8'd112 - {4'd0, lz}), nm, 13'd0};
      end
    end else if (ex == 5'h1f) begin
      r = {s, 8'hff, man, 13'd0};
    end else begin
      r = {s, 8'({3'd0, ex} + 8'd112), man, 13'd0};
    end
    return r;
  endfunction
endpackage

// ===== rtl/i8dq_front.sv =====
// Front part: tracks the byte position, assembles and screens the scale.
// Depends on i8dq_pkg.
`timescale 1ns / 1ps
module i8dq_front #(
  parameter int unsigned BlockElements = i8dq_pkg::BlockElemDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 scale_limit_we_i,
  input  logic [30:0]          scale_limit_wdata_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [7:0]           data_byte_i,
  output logic                 push_o,
  output i8dq_pkg::work_t      push_data_o,
  input  logic                 full_i
);
  // At least five bits so that the element index can always be sliced
  localparam int unsigned PosW = ($clog2(BlockElements + 2) < 5) ? 5 :
                                 $clog2(BlockElements + 2);

  logic [PosW-1:0] pos_q, pos_d;
  logic [7:0]      low_q;
  logic [31:0]     scale_q;
  logic [30:0]     limit_q;
  logic [31:0]     wide;
  logic [PosW-1:0] idx;
  logic            acc;

  assign in_ready_o = !full_i;
  assign acc        = in_valid_i && in_ready_o;
  assign wide       = i8dq_pkg::half_to_single({data_byte_i, low_q});
  assign idx        = pos_q - PosW'(2);

  // Classify the byte and build the work item
  always_comb begin
    pos_d  = pos_q;
    push_o = 1'b0;
    push_data_o.quant = data_byte_i;
    push_data_o.scale = scale_q;
    push_data_o.index = idx[4:0];
    push_data_o.last  = (idx == PosW'(BlockElements - 1));
    if (acc) begin
      if (pos_q == PosW'(0)) begin
        pos_d = PosW'(1);
      end else if (pos_q == PosW'(1)) begin
        pos_d = PosW'(2);
      end else begin
        push_o = 1'b1;
        pos_d  = push_data_o.last ? PosW'(0) : pos_q + PosW'(1);
      end
    end
  end

  // Hold the position and the limit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      limit_q <= i8dq_pkg::ScaleLimitReset;
    end else begin
      pos_q <= pos_d;
      if (scale_limit_we_i) limit_q <= scale_limit_wdata_i;
    end
  end

  // Capture scale bytes; screen the widened scale
  always_ff @(posedge clk_i) begin
    if (acc && pos_q == PosW'(0)) low_q <= data_byte_i;
    if (acc && pos_q == PosW'(1)) begin
      if (wide[30:0] >= 31'h7f800000 || wide[30:0] > limit_q) scale_q <= '0;
      else scale_q <= wide;
    end
  end
endmodule

// ===== rtl/i8dq_queue.sv =====
// Short queue between the front and back parts.
// Depends on i8dq_pkg.
`timescale 1ns / 1ps
module i8dq_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  i8dq_pkg::work_t push_data_i,
  output logic            full_o,
  output logic            valid_o,
  output i8dq_pkg::work_t pop_data_o,
  input  logic            pop_i
);
  localparam int unsigned D = i8dq_pkg::QueueDepth;
  localparam int unsigned AW = $clog2(D);

  i8dq_pkg::work_t mem_q [D];
  logic [AW-1:0]   wp_q, rp_q;
  logic [AW:0]     cnt_q;

  assign full_o     = (cnt_q == (AW+1)'(D));
  assign valid_o    = (cnt_q != '0);
  assign pop_data_o = mem_q[rp_q];

  // Advance pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wp_q <= wp_q + AW'(1);
      if (pop_i)  rp_q <= rp_q + AW'(1);
      cnt_q <= cnt_q + (AW+1)'(push_i) - (AW+1)'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= push_data_i;
  end
endmodule

// ===== rtl/i8dq_back.sv =====
// Back part: quant times scale product, truncated to single precision, and output register.
// Depends on i8dq_pkg.
`timescale 1ns / 1ps
module i8dq_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  input  i8dq_pkg::work_t data_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [31:0]     weight_bits_o,
  output logic [4:0]      element_index_o,
  output logic            last_in_block_o
);
  logic        vld_q;
  logic        sgn;
  logic [7:0]  mag;
  logic [7:0]  ex;
  logic [23:0] sig;
  logic [31:0] prod;
  logic [2:0]  sh;
  logic [31:0] res;

  assign pop_o = valid_i && (!vld_q || out_ready_i);
  assign sgn   = data_i.quant[7] ^ data_i.scale[31];
  assign mag   = data_i.quant[7] ? 8'(-data_i.quant) : data_i.quant;
  assign ex    = data_i.scale[30:23];
  assign sig   = {1'b1, data_i.scale[22:0]};
  assign prod  = sig * mag;

  // Normalise: product of 24-bit significand and 8-bit magnitude
  always_comb begin
    sh  = 3'd0;
    res = {sgn, 31'd0};
    for (int i = 24; i < 32; i++) begin
      if (prod[i]) sh = 3'(i - 23);
    end
    // Scale is normal or zero after screening; zero gives a signed zero
    if (mag != 8'd0 && ex != 8'd0) begin
      res = {sgn, 8'(ex + {5'd0, sh}), 23'(prod >> sh)};
    end
  end

  // Hold the result until taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= 1'b0;
    else if (pop_o) vld_q <= 1'b1;
    else if (out_ready_i) vld_q <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      weight_bits_o   <= res;
      element_index_o <= data_i.index;
      last_in_block_o <= data_i.last;
    end
  end

  assign out_valid_o = vld_q;
endmodule

// ===== rtl/int8_block_dequantizer_unit.sv =====
// An accepted quant byte enters the queue, then the output register.
// One byte per cycle unless the queue is full; two scale bytes give no result.
// A two-entry queue parts the byte tracker from the multiply and output register.
// Reset: asynchronous active low; position to block start, limit to 10000.0.
// Top level of the int8 block dequantizer; depends on i8dq_pkg and submodules.
`timescale 1ns / 1ps
module int8_block_dequantizer_unit #(
  parameter int unsigned BlockElements = i8dq_pkg::BlockElemDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        scale_limit_we_i,
  input  logic [30:0] scale_limit_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] weight_bits_o,
  output logic [4:0]  element_index_o,
  output logic        last_in_block_o
);
  logic            push, full, qv, pop;
  i8dq_pkg::work_t pd, qd;

  i8dq_front #(.BlockElements(BlockElements)) u_front (
    .clk_i, .rst_ni, .scale_limit_we_i(scale_limit_we_i),
    .scale_limit_wdata_i(scale_limit_i), .in_valid_i, .in_ready_o, .data_byte_i,
    .push_o(push), .push_data_o(pd), .full_i(full)
  );

  i8dq_queue u_queue (
    .clk_i, .rst_ni, .push_i(push), .push_data_i(pd), .full_o(full),
    .valid_o(qv), .pop_data_o(qd), .pop_i(pop)
  );

  i8dq_back u_back (
    .clk_i, .rst_ni, .valid_i(qv), .data_i(qd), .pop_o(pop), .out_valid_o,
    .out_ready_i, .weight_bits_o, .element_index_o, .last_in_block_o
  );
endmodule

// ===== rtl/i8dq_checker.sv =====
// Port-level checker for the int8 block dequantizer, bound to the top level.
// Depends on the top level's ports only.
`timescale 1ns / 1ps
module i8dq_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [31:0] weight_bits_o,
  input logic [4:0]  element_index_o
);
  // Stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(weight_bits_o) &&
    $stable(element_index_o))
    else $error("result changed while stalled");
  // No result without an earlier accepted item
  a_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && in_ready_o, 2))
    else $error("result without input");
  // Ready returns once output drains
  a_rdy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |=> in_ready_o)
    else $error("input stalled with empty output");
endmodule

bind int8_block_dequantizer_unit i8dq_checker u_chk (
  .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i,
  .weight_bits_o, .element_index_o
);

// ===== sim/testbench.sv =====
// Self-checking testbench for int8_block_dequantizer_unit: table-driven and random byte streams.
// Depends on i8dq_pkg and the dequantizer RTL; an internal predictor computes each weight the table does not give.
`timescale 1ns / 1ps
module testbench;

  localparam int unsigned WatchdogLimit = 5000;
  localparam int unsigned HoldCycles    = 300;

  typedef struct {
    logic [31:0] weight;
    logic [4:0]  index;
    logic        last;
  } weight_t;

  typedef struct {
    logic [7:0]  data;
    bit          typed;
    logic [31:0] weight;
  } row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        scale_limit_we_i;
  logic [30:0] scale_limit_i;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [7:0]  data_byte_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [31:0] weight_bits_o;
  logic [4:0]  element_index_o;
  logic        last_in_block_o;

  // Predictor state
  int unsigned pred_pos;
  logic [7:0]  pred_scale_lo;
  logic [31:0] pred_scale;
  logic [30:0] pred_limit;

  weight_t     weights_due[$];
  int unsigned mismatches;
  int unsigned weights_seen;
  int unsigned bytes_sent;
  int unsigned idle_cycles;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  bit          hold_req;
  int unsigned hold_left;
  logic [15:0] scale_pick [9];
  logic [30:0] limit_pick [5];
  row_t        rows [$];

  int8_block_dequantizer_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .scale_limit_we_i(scale_limit_we_i),
    .scale_limit_i   (scale_limit_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .data_byte_i     (data_byte_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .weight_bits_o   (weight_bits_o),
    .element_index_o (element_index_o),
    .last_in_block_o (last_in_block_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Widen a half pattern to single bits
  function automatic logic [31:0] widen_half(input logic [15:0] h);
    logic [31:0] r;
    int          k;
    logic [22:0] fr;
    r = {h[15], 31'd0};
    k = -1;
    if (h[14:10] == 5'd0) begin
      for (int i = 0; i < 10; i++) if (h[i]) k = i;
      if (k >= 0) begin
        fr = 23'({h[9:0], 13'd0} << (10 - k));
        r = {h[15], 8'(k + 103), fr};
      end
    end else if (h[14:10] == 5'h1f) begin
      r = {h[15], 8'hff, h[9:0], 13'd0};
    end else begin
      r = {h[15], 8'(h[14:10] + 112), h[9:0], 13'd0};
    end
    return r;
  endfunction

  // Product of a signed quant and a single scale, truncated to single precision
  function automatic logic [31:0] scale_quant(input logic [7:0] q, input logic [31:0] s);
    logic        sg;
    logic [7:0]  mq;
    logic [31:0] prod;
    int          p;
    sg = q[7] ^ s[31];
    mq = q[7] ? 8'(-q) : q;
    if (mq == 8'd0 || s[30:0] == 31'd0) return {sg, 31'd0};
    prod = mq * {8'd0, 1'b1, s[22:0]};
    p = 0;
    for (int i = 0; i < 32; i++) if (prod[i]) p = i;
    prod = prod >> (p - 23);
    return {sg, 8'(s[30:23] + p - 23), prod[22:0]};
  endfunction

  // Advance the predictor by one accepted byte
  function automatic void dequantize_byte(input logic [7:0] b, output bit has,
                                          output weight_t w);
    logic [31:0] wide;
    has = 1'b0;
    w = '{default: '0};
    if (pred_pos == 0) begin
      pred_scale_lo = b;
      pred_pos = 1;
    end else if (pred_pos == 1) begin
      wide = widen_half({b, pred_scale_lo});
      if (wide[30:0] >= 31'h7f800000 || wide[30:0] > pred_limit) wide = '0;
      pred_scale = wide;
      pred_pos = 2;
    end else begin
      has = 1'b1;
      w.weight = scale_quant(b, pred_scale);
      w.index = 5'(pred_pos - 2);
      w.last = (pred_pos - 1 >= i8dq_pkg::BlockElemDefault);
      pred_pos = w.last ? 0 : pred_pos + 1;
    end
  endfunction

  // Offer one item, hold it until accepted, then book its expectation
  task automatic send_byte(input logic [7:0] b, input bit typed, input logic [31:0] tw);
    bit      has;
    weight_t w;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    data_byte_i <= b;
    do @(posedge clk_i); while (!in_ready_o);
    dequantize_byte(b, has, w);
    if (has) begin
      if (typed) w.weight = tw;
      weights_due.push_back(w);
    end
    bytes_sent++;
    @(negedge clk_i);
  endtask

  // Let the block drain, then write the limit register
  task automatic write_limit(input logic [30:0] v);
    in_valid_i <= 1'b0;
    while (weights_due.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
    scale_limit_we_i <= 1'b1;
    scale_limit_i    <= v;
    @(negedge clk_i);
    scale_limit_we_i <= 1'b0;
    pred_limit = v;
  endtask

  function automatic logic [7:0] random_byte();
    logic [15:0] h;
    if (pred_pos == 0 || pred_pos == 1) begin
      h = ($urandom_range(2) == 0) ? 16'($urandom) : scale_pick[$urandom_range(8)];
      return (pred_pos == 0) ? h[7:0] : h[15:8];
    end
    return 8'($urandom);
  endfunction

  // Receiver: random stalls plus long holds, restarted while a hold is requested
  always @(negedge clk_i) begin
    if (hold_req && hold_left == 0) hold_left <= HoldCycles;
    if (hold_left != 0) begin
      out_ready_i <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Check each delivered weight against the oldest expectation
  always @(posedge clk_i) begin
    weight_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      weights_seen++;
      if (weights_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected weight %h", weight_bits_o);
      end else begin
        e = weights_due.pop_front();
        if (e.weight !== weight_bits_o || e.index !== element_index_o ||
            e.last !== last_in_block_o) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp %h/%0d/%b got %h/%0d/%b", e.weight, e.index, e.last,
                     weight_bits_o, element_index_o, last_in_block_o);
        end
      end
    end
  end

  // Watchdog on cycles without any handshake
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchdogLimit) begin
      $display("watchdog expired");
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    rst_ni = 1'b0;
    scale_limit_we_i = 1'b0;
    scale_limit_i = '0;
    in_valid_i = 1'b0;
    data_byte_i = '0;
    out_ready_i = 1'b0;
    hold_req = 1'b0;
    hold_left = 0;
    idle_cycles = 0;
    mismatches = 0;
    weights_seen = 0;
    bytes_sent = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    pred_pos = 0;
    pred_scale_lo = '0;
    pred_scale = '0;
    pred_limit = i8dq_pkg::ScaleLimitReset;
    // Scales: infinities, NaN, subnormals, signed zero, half max, near the default limit
    scale_pick = '{16'h7c00, 16'hfc00, 16'h7e01, 16'h0001, 16'h83ff,
                   16'h8000, 16'h7bff, 16'h70e2, 16'h70e3};
    limit_pick = '{31'd0, 31'h7f7fffff, i8dq_pkg::ScaleLimitReset, 31'h3f800000,
                   31'h00000001};
    // Directed block at scale 1.0: quant extremes and signed zero
    rows = '{'{8'h00, 1'b0, 32'h0}, '{8'h3c, 1'b0, 32'h0},
             '{8'h7f, 1'b1, 32'h42fe0000}, '{8'h80, 1'b1, 32'hc3000000},
             '{8'h00, 1'b1, 32'h00000000}, '{8'h01, 1'b1, 32'h3f800000},
             '{8'hff, 1'b1, 32'hbf800000}, '{8'h55, 1'b0, 32'h0},
             '{8'haa, 1'b0, 32'h0}};
    for (int i = 0; i < 25; i++) rows.push_back('{8'(i * 37 + 3), 1'b0, 32'h0});
    // Next block: negative scale -2.0 gives -0.0 for quant zero
    rows.push_back('{8'h00, 1'b0, 32'h0});
    rows.push_back('{8'hc0, 1'b0, 32'h0});
    rows.push_back('{8'h00, 1'b1, 32'h80000000});
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (rows[i]) send_byte(rows[i].data, rows[i].typed, rows[i].weight);

    // Random phases: each idling pattern under a fresh limit, then repeated long holds
    for (int ph = 0; ph < 5; ph++) begin
      write_limit(ph == 4 ? 31'($urandom_range(32'h7f7fffff)) : limit_pick[ph]);
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 69; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 69; end
        3: begin send_idle_pct = 7;  recv_stall_pct = 7;  end
        default: begin send_idle_pct = 0; recv_stall_pct = 0; hold_req = 1'b1; end
      endcase
      for (int n = 0; n < 400; n++) begin
        send_byte(random_byte(), 1'b0, 32'h0);
        if (n == 20) hold_req = 1'b0;
      end
    end

    in_valid_i <= 1'b0;
    while (weights_due.size() != 0) @(negedge clk_i);
    repeat (10) @(negedge clk_i);
    $display("covered %0d bytes and %0d weights over five limits and idling patterns",
             bytes_sent, weights_seen);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
